[design/mvm_pkg.sv]
// Shared types and constants for the matrix-vector multiply block.
package mvm_pkg;

    localparam int MAX_ROWS_DEF = 16;
    localparam int MAX_COLS_DEF = 16;

    localparam int VAL_W  = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 40;
    localparam int CFG_W  = 5;
    localparam int IDX_W  = 4;

    localparam logic       FUNC_WEIGHT = 1'b0;
    localparam logic       FUNC_VECTOR = 1'b1;
    localparam logic       CFG_ROWS    = 1'b0;
    localparam logic       CFG_COLS    = 1'b1;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef struct packed {
        logic                    func;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0]        row_index;
        logic signed [VAL_W-1:0] sum;
        logic                    saturated;
        logic                    last;
    } t_out_word;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_ring_ctl;

endpackage

[design/mvm_wram.sv]
// Weight store: single write port, registered read port.
module mvm_wram #(
    parameter int DEPTH = mvm_pkg::MAX_ROWS_DEF * mvm_pkg::MAX_COLS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [mvm_pkg::VAL_W-1:0]    i_wdata,
    input  logic [AW-1:0]                i_raddr,
    output logic [mvm_pkg::VAL_W-1:0]    o_rdata
);

    logic [mvm_pkg::VAL_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[design/mvm_cell.sv]
// One accumulator cell of the rotating row ring.
module mvm_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mvm_pkg::t_ring_ctl          i_ctl,
    input  logic [mvm_pkg::ACC_W-1:0]   i_d,
    output logic [mvm_pkg::ACC_W-1:0]   o_q
);

    logic [mvm_pkg::ACC_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.shift) begin
            r_acc <= i_d;
        end
    end

    assign o_q = r_acc;

endmodule

[design/matrix_vector_multiply.sv]
// Top level: fixed-point matrix-vector multiply with a ring of row accumulators.
//
// Usage:
//   Input words are taken on i_clk when start is high and busy is low.
//   func 0 stores a Q8.8 weight at (row, col); busy stays low.
//   func 1 carries vector element col. Busy then rises:
//   the weight RAM read port walks the rows one per cycle, feeding the single
//   multiplier, and the ring of MAX_ROWS accumulator cells rotates one place
//   per product so that the head cell always holds the row being updated.
//   An element with col at or above cols_used (taken as 1 when zero) is dropped.
//   On the last used column the ring rotates once more, emitting one result
//   word per used row (o_valid for one cycle each, consecutive, last flagged)
//   and clearing every accumulator, so the worst case per element, busy
//   through both ring rotations, comes on the last used column.
//   Results appear in the cycle after the head cell is read; the receiver
//   cannot stall them.
//   Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once and
//   belong in idle periods. Reset clears accumulators and control, sets
//   rows_used and cols_used to 16; weights are undefined until written.
module matrix_vector_multiply #(
    parameter int MAX_ROWS = mvm_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = mvm_pkg::MAX_COLS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  mvm_pkg::t_in_word           i_in,
    output logic                        o_valid,
    output mvm_pkg::t_out_word          o_out,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [mvm_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(MAX_ROWS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]                       r_state, n_state;
    logic [CNT_W-1:0]                 r_k, n_k;
    logic [AW-1:0]                    r_addr, n_addr;
    logic                             r_emit, n_emit;
    logic signed [mvm_pkg::VAL_W-1:0] r_x;
    logic [mvm_pkg::CFG_W-1:0]        r_rows_used, r_cols_used;
    logic                             r_v1, r_en1, r_v2;
    logic signed [mvm_pkg::PROD_W-1:0] r_prod;
    logic [mvm_pkg::VAL_W-1:0]        w_rdata;
    logic [CNT_W-1:0]                 w_nrows;
    logic [mvm_pkg::CFG_W:0]          w_ncols;
    logic                             w_accept, w_wr, w_issue;
    logic [AW-1:0]                    w_waddr;
    mvm_pkg::t_ring_ctl               w_ctl;
    logic [mvm_pkg::ACC_W-1:0]        w_acc [MAX_ROWS];
    logic [mvm_pkg::ACC_W-1:0]        w_tail;
    logic [mvm_pkg::ACC_W-1:0]        w_head;
    logic                             w_sat;
    mvm_pkg::t_out_word               w_res;

    // Clamped counts.
    always_comb begin
        if (r_rows_used == '0) begin
            w_nrows = CNT_W'(1);
        end else if (int'(r_rows_used) > MAX_ROWS) begin
            w_nrows = CNT_W'(MAX_ROWS);
        end else begin
            w_nrows = CNT_W'(r_rows_used);
        end
        if (r_cols_used == '0) begin
            w_ncols = (mvm_pkg::CFG_W + 1)'(1);
        end else if (int'(r_cols_used) > MAX_COLS) begin
            w_ncols = (mvm_pkg::CFG_W + 1)'(MAX_COLS);
        end else begin
            w_ncols = (mvm_pkg::CFG_W + 1)'(r_cols_used);
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_wr     = w_accept && (i_in.func == mvm_pkg::FUNC_WEIGHT)
                      && (int'(i_in.row) < MAX_ROWS) && (int'(i_in.col) < MAX_COLS);
    assign w_waddr  = AW'(AW'(i_in.row) * AW'(MAX_COLS) + AW'(i_in.col));
    assign w_issue  = (r_state == ST_MAC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_used <= mvm_pkg::CFG_RESET;
            r_cols_used <= mvm_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mvm_pkg::CFG_ROWS: r_rows_used <= i_cfg_data;
                mvm_pkg::CFG_COLS: r_cols_used <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_addr  = r_addr;
        n_emit  = r_emit;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_in.func == mvm_pkg::FUNC_VECTOR)
                    && ((mvm_pkg::CFG_W + 1)'(i_in.col) < w_ncols)) begin
                    n_state = ST_MAC;
                    n_k     = '0;
                    n_addr  = AW'(i_in.col);
                    n_emit  = ((mvm_pkg::CFG_W + 1)'(i_in.col) == w_ncols - 1'b1);
                end
            end
            ST_MAC: begin
                n_k    = r_k + 1'b1;
                n_addr = AW'(r_addr + AW'(MAX_COLS));
                if (r_k == CNT_W'(MAX_ROWS - 1)) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (!r_v1 && !r_v2) begin
                    n_k     = '0;
                    n_state = r_emit ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                n_k = r_k + 1'b1;
                if (r_k == CNT_W'(MAX_ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_emit  <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_emit  <= n_emit;
            r_v1    <= w_issue;
            r_v2    <= r_v1;
        end
    end

    // Payload pipeline.
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_en1  <= w_issue && (r_k < w_nrows);
        if (w_accept) begin
            r_x <= i_in.value;
        end
        if (r_en1) begin
            r_prod <= $signed(w_rdata) * r_x;
        end else begin
            r_prod <= '0;
        end
    end

    mvm_wram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_wram (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (w_waddr),
        .i_wdata (i_in.value),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // Accumulator ring: head is cell 0, the updated value re-enters at the tail.
    assign w_ctl.shift = r_v2 || (r_state == ST_EMIT);
    assign w_ctl.clear = (r_state == ST_EMIT);
    assign w_head      = w_acc[0];
    assign w_tail      = w_ctl.clear ? '0
                       : mvm_pkg::ACC_W'(w_head + {{(mvm_pkg::ACC_W - mvm_pkg::PROD_W)
                                                    {r_prod[mvm_pkg::PROD_W-1]}}, r_prod});

    for (genvar gi = 0; gi < MAX_ROWS; gi++) begin : g_cell
        if (gi == MAX_ROWS - 1) begin : g_tail
            mvm_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_d     (w_tail),
                .o_q     (w_acc[gi])
            );
        end else begin : g_mid
            mvm_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_d     (w_acc[gi+1]),
                .o_q     (w_acc[gi])
            );
        end
    end

    // Floor shift by 8 and saturate to Q8.8.
    assign w_sat = !((&w_head[mvm_pkg::ACC_W-1:23]) || !(|w_head[mvm_pkg::ACC_W-1:23]));

    always_comb begin
        w_res.row_index = mvm_pkg::IDX_W'(r_k);
        w_res.saturated = w_sat;
        w_res.last      = (r_k == w_nrows - 1'b1);
        if (w_sat) begin
            w_res.sum = w_head[mvm_pkg::ACC_W-1] ? 16'sh8000 : 16'sh7fff;
        end else begin
            w_res.sum = w_head[23:8];
        end
    end

    logic r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == ST_EMIT) && (r_k < w_nrows);
        end
    end

    always_ff @(posedge i_clk) begin
        o_out <= w_res;
    end

    assign o_valid = r_valid;

endmodule

[design/mvm_chk.sv]
// Port-level checks for the matrix-vector multiply block, bound to the top level.
module mvm_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               busy,
    input logic               o_valid,
    input mvm_pkg::t_out_word o_out
);

    a_res_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result word without a preceding busy period");

    a_burst_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.last |=> !o_valid)
        else $error("result word after the last one of a vector");

    a_burst_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.last |=> o_valid)
        else $error("gap inside a result burst");

    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.last |=> o_out.row_index == $past(o_out.row_index) + 4'd1)
        else $error("result rows out of order");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.saturated |-> o_out.sum == 16'sh7fff || o_out.sum == 16'sh8000)
        else $error("saturated word not at a range limit");

endmodule

bind matrix_vector_multiply mvm_chk u_mvm_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .busy    (busy),
    .o_valid (o_valid),
    .o_out   (o_out)
);
